/* hdl/i2cbm_pkg.sv */
// Shared types and constants for the I2C bit-level master.
`timescale 1ns / 1ps

package i2cbm_pkg;

    localparam int PHASE_W = 16;
    localparam int WAIT_W  = 24;
    localparam int CFG_W   = 24;

    localparam logic [PHASE_W-1:0] PHASE_TICKS_RESET = 16'd50;
    localparam logic [WAIT_W-1:0]  STOP_WAIT_RESET   = 24'd50000;

    // Configuration register indexes.
    localparam logic CFG_PHASE_TICKS = 1'b0;
    localparam logic CFG_STOP_WAIT   = 1'b1;

    // Command opcodes.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] opcode;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } cmd_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic [7:0] read_data;
        logic       read_valid;
    } res_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_ticks;
        logic [WAIT_W-1:0]  stop_wait_ticks;
    } cfg_t;

endpackage

/* hdl/i2cbm_seq.sv */
// Bus phase sequencer: holds the bus state and computes one tick per transaction.
`timescale 1ns / 1ps

module i2cbm_seq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  i2cbm_pkg::cmd_t   cmd,
    input  i2cbm_pkg::cfg_t   cfg,
    output i2cbm_pkg::res_t   result
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_S1,
        PH_S2,
        PH_S3,
        PH_S4,
        PH_S5,
        PH_P1,
        PH_P2,
        PH_P3,
        PH_P4,
        PH_WAIT,
        PH_BLO,
        PH_BHI,
        PH_BEND
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [1:0]                 kind_reg, kind_next;
    logic [3:0]                 bit_reg, bit_next;
    logic [7:0]                 shift_reg, shift_next;
    logic [i2cbm_pkg::WAIT_W-1:0] timer_reg, timer_next;
    logic                       scl_reg, scl_next;
    logic                       sda_reg, sda_next;
    logic                       drive_reg, drive_next;
    logic                       ack_reg, ack_next;
    logic [7:0]                 rx_reg, rx_next;

    logic                       do_enter;
    phase_t                     target;
    logic                       rv;
    logic [i2cbm_pkg::WAIT_W-1:0] timer_inc;
    logic [i2cbm_pkg::WAIT_W-1:0] limit;
    logic [i2cbm_pkg::PHASE_W-1:0] phase_eff;
    logic [3:0]                 bit_inc;

    assign phase_eff = (cfg.phase_ticks == '0) ? i2cbm_pkg::PHASE_W'(1) : cfg.phase_ticks;
    assign limit     = (phase_reg == PH_WAIT) ? cfg.stop_wait_ticks
                                              : {{(i2cbm_pkg::WAIT_W-i2cbm_pkg::PHASE_W){1'b0}},
                                                 phase_eff};
    assign timer_inc = timer_reg + 1'b1;
    assign bit_inc   = bit_reg + 1'b1;

    always_comb
    begin
        kind_next  = kind_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        timer_next = timer_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        do_enter   = 1'b0;
        target     = PH_IDLE;
        rv         = 1'b0;

        // First decide where to go and update the data registers.
        if (phase_reg == PH_IDLE)
        begin
            if (cmd.cmd_valid)
            begin
                kind_next = cmd.opcode;
                do_enter  = 1'b1;
                case (cmd.opcode)
                    i2cbm_pkg::OP_START: target = PH_S1;
                    i2cbm_pkg::OP_STOP:  target = PH_P1;
                    i2cbm_pkg::OP_WRITE:
                    begin
                        target     = PH_BLO;
                        bit_next   = 4'd0;
                        shift_next = cmd.write_data;
                    end
                    default:
                    begin
                        target     = PH_BLO;
                        bit_next   = 4'd0;
                        shift_next = 8'd0;
                        ack_next   = cmd.send_ack;
                    end
                endcase
            end
        end
        else
        begin
            timer_next = timer_inc;
            if (timer_inc >= limit)
            begin
                do_enter = 1'b1;
                case (phase_reg)
                    PH_S1:  target = PH_S2;
                    PH_S2:  target = PH_S3;
                    PH_S3:  target = PH_S4;
                    PH_S4:  target = PH_S5;
                    PH_P1:  target = PH_P2;
                    PH_P2:  target = PH_P3;
                    PH_P3:  target = PH_P4;
                    PH_BLO: target = PH_BHI;
                    PH_P4:  target = (cfg.stop_wait_ticks == '0) ? PH_IDLE : PH_WAIT;
                    PH_BHI:
                    begin
                        if (bit_reg < 4'd8)
                        begin
                            if (kind_reg == i2cbm_pkg::OP_READ)
                                shift_next = {shift_reg[6:0], cmd.sda_in};
                            else
                                shift_next = {shift_reg[6:0], 1'b0};
                        end
                        bit_next = bit_inc;
                        target   = (bit_inc >= 4'd9) ? PH_BEND : PH_BLO;
                    end
                    PH_BEND:
                    begin
                        if (kind_reg == i2cbm_pkg::OP_READ)
                        begin
                            rx_next = shift_reg;
                            rv      = 1'b1;
                        end
                        target = PH_IDLE;
                    end
                    default: target = PH_IDLE;
                endcase
            end
        end

        // Then apply the pin levels of the phase being entered.
        phase_next = phase_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drive_next = drive_reg;
        if (do_enter)
        begin
            phase_next = target;
            timer_next = '0;
            case (target)
                PH_S1:
                begin
                    scl_next   = 1'b0;
                    drive_next = 1'b1;
                end
                PH_S2: sda_next = 1'b1;
                PH_S3: scl_next = 1'b1;
                PH_S4: sda_next = 1'b0;
                PH_S5: scl_next = 1'b0;
                PH_P1:
                begin
                    scl_next   = 1'b0;
                    drive_next = 1'b1;
                end
                PH_P2: sda_next = 1'b0;
                PH_P3: scl_next = 1'b1;
                PH_P4: sda_next = 1'b1;
                PH_BLO:
                begin
                    scl_next = 1'b0;
                    if (bit_next < 4'd8)
                    begin
                        if (kind_next == i2cbm_pkg::OP_WRITE)
                        begin
                            drive_next = 1'b1;
                            sda_next   = shift_next[7];
                        end
                        else
                        begin
                            drive_next = 1'b0;
                            sda_next   = 1'b1;
                        end
                    end
                    else if (kind_next == i2cbm_pkg::OP_WRITE)
                    begin
                        // Ack slot of a write: release SDA for the slave.
                        drive_next = 1'b0;
                        sda_next   = 1'b1;
                    end
                    else
                    begin
                        drive_next = 1'b1;
                        sda_next   = ~ack_next;
                    end
                end
                PH_BHI:  scl_next = 1'b1;
                PH_BEND: scl_next = 1'b0;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        result.scl_out    = scl_next;
        result.sda_out    = sda_next;
        result.sda_drive  = drive_next;
        result.busy_res   = (phase_next != PH_IDLE);
        result.read_data  = rx_next;
        result.read_valid = rv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kind_reg  <= 2'd0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            timer_reg <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            drive_reg <= 1'b1;
            ack_reg   <= 1'b0;
            rx_reg    <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            timer_reg <= timer_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            drive_reg <= drive_next;
            ack_reg   <= ack_next;
            rx_reg    <= rx_next;
        end
    end

endmodule

/* hdl/i2c_bit_level_master.sv */
// Top level of the I2C bit-level master: handshakes, configuration and result register.
`timescale 1ns / 1ps

// Each accepted input transaction is one tick of the I2C bus sequencer and
// yields exactly one result transaction, which carries the bus pins and status
// after that tick. The block takes one transaction per clock when in_stall is
// low; its result sits in the output register from the next cycle on. The per-tick
// state update in the phase sequencer sets that figure, and a stalled output holds
// the input side only while the output register is full. Commands are taken only on a
// tick that finds the sequencer idle; a command offered while busy is ignored.
// Configuration writes take effect at once and belong to idle periods.

module i2c_bit_level_master
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  i2cbm_pkg::cmd_t               in_data,

    output logic                          out_valid,
    input  logic                          out_stall,
    output i2cbm_pkg::res_t               out_data,

    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [i2cbm_pkg::CFG_W-1:0]   cfg_data
);

    i2cbm_pkg::cfg_t cfg_reg;
    i2cbm_pkg::res_t result;
    i2cbm_pkg::res_t out_data_reg;
    logic            out_valid_reg;
    logic            in_fire;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_fire   = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_ticks     <= i2cbm_pkg::PHASE_TICKS_RESET;
            cfg_reg.stop_wait_ticks <= i2cbm_pkg::STOP_WAIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2cbm_pkg::CFG_PHASE_TICKS:
                    cfg_reg.phase_ticks <= cfg_data[i2cbm_pkg::PHASE_W-1:0];
                default:
                    cfg_reg.stop_wait_ticks <= cfg_data[i2cbm_pkg::WAIT_W-1:0];
            endcase
        end
    end

    i2cbm_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (in_fire),
        .cmd    (in_data),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= result;
        end
    end

endmodule
